// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/qse_pkg.sv -----
// Package of constants and types for the quicksort engine.
package qse_pkg;
    localparam int DEPTH = 32;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SD = 2 * DEPTH + 2;
    localparam int SW = $clog2(SD + 1);
    typedef logic [AW-1:0] t_addr;
    typedef struct packed {
        logic         we;
        t_addr        waddr;
        logic [31:0]  wdata;
        t_addr        raddr;
    } t_mem_req;
endpackage

// ----- rtl/core/quicksort_engine_unit.sv -----
// Top level of the quicksort engine: load, sort, emit sequencer.
//
// Slave channel takes one value per beat; tlast marks the last value of a set.
// Loading accepts back-to-back beats. After the last beat the set is sorted in
// place with Hoare partitioning, a middle pivot and a range stack held in
// memory. The element store has a registered read port, so each compare
// takes a read state and a test state; a swap writes in S_SW1 and S_SW2. The
// sorted set then streams out on the master channel, each beat read in S_ERD
// and registered in S_EWT, with tlast on the final beat and the truncated flag
// on every beat. Values beyond the store depth are dropped and flagged. The
// slave side is not ready while a set is sorted or emitted. A receiver stall
// holds the output beat in its register. Reset clears the element count and
// returns to loading; the store itself is not cleared.
`include "assert_macros.svh"
module quicksort_engine_unit import qse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_value
    output logic        m_axis_tlast,   // last_out
    output logic        m_axis_tuser    // truncated
);
    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_POPW, S_PIV, S_PIVW, S_RI, S_TI, S_RJ, S_TJ,
        S_SW1, S_SW2, S_PUSH, S_ERD, S_EWT
    } t_state;

    t_state          r_st;
    logic [CW-1:0]   r_cnt;
    logic            r_ovf;
    logic [SW-1:0]   r_sp;
    logic [AW+1:0]   r_lo, r_hi, r_i, r_j;
    logic [31:0]     r_piv, r_vi, r_vj;
    logic [CW-1:0]   r_k;
    logic            r_p2;
    logic            r_ov;
    logic [31:0]     r_od;
    logic            r_ol;

    t_mem_req        mreq;
    logic [31:0]     rdata;
    logic            st_we;
    logic [SW-1:0]   st_wa;
    logic [2*AW-1:0] st_wd;
    logic [2*AW-1:0] st_rd;
    logic [AW+1:0]   mid;

    qse_store u_store (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));
    qse_stack u_stack (.i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
                       .i_raddr(r_sp - SW'(1)), .o_rdata(st_rd));

    logic s_acc;
    assign s_axis_tready = (r_st == S_LOAD);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        mreq.we = 1'b0;
        mreq.waddr = r_cnt[AW-1:0];
        mreq.wdata = s_axis_tdata ^ 32'h8000_0000;
        mreq.raddr = r_i[AW-1:0];
        unique case (r_st)
            S_LOAD: mreq.we = s_acc && (r_cnt < CW'(DEPTH));
            S_PIV: mreq.raddr = mid[AW-1:0];
            S_RJ: mreq.raddr = r_j[AW-1:0];
            S_SW1: begin
                mreq.we = 1'b1; mreq.waddr = r_i[AW-1:0]; mreq.wdata = r_vj;
            end
            S_SW2: begin
                mreq.we = 1'b1; mreq.waddr = r_j[AW-1:0]; mreq.wdata = r_vi;
            end
            S_ERD: mreq.raddr = r_k[AW-1:0];
            default: ;
        endcase
    end

    always_comb begin
        st_we = 1'b0;
        st_wa = r_sp;
        st_wd = {r_i[AW-1:0], r_hi[AW-1:0]};
        if (r_st == S_PUSH) begin
            if (!r_p2) begin
                st_we = ($signed(r_j) > $signed(r_lo));
                st_wd = {r_lo[AW-1:0], r_j[AW-1:0]};
            end else begin
                st_we = ($signed(r_hi) > $signed(r_i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_sp <= '0;
            r_ov <= 1'b0; r_p2 <= 1'b0; r_k <= '0;
        end else begin
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_st)
                S_LOAD: if (s_acc) begin
                    if (r_cnt < CW'(DEPTH)) r_cnt <= r_cnt + CW'(1);
                    else r_ovf <= 1'b1;
                    if (s_axis_tlast) begin
                        r_k <= '0;
                        if (r_cnt < CW'(DEPTH) ? (r_cnt >= CW'(1)) : 1'b1) begin
                            r_lo <= '0;
                            r_hi <= (r_cnt < CW'(DEPTH)) ? (AW+2)'(r_cnt)
                                                         : (AW+2)'(r_cnt - CW'(1));
                            r_st <= S_PIV;
                            r_sp <= '0;
                        end else begin
                            r_st <= S_ERD;
                        end
                    end
                end
                S_POP: begin
                    if (r_sp == '0) r_st <= S_ERD;
                    else r_st <= S_POPW;
                end
                S_POPW: begin
                    r_lo <= {2'b00, st_rd[2*AW-1:AW]};
                    r_hi <= {2'b00, st_rd[AW-1:0]};
                    r_sp <= r_sp - SW'(1);
                    r_st <= S_PIV;
                end
                S_PIV: begin
                    r_i <= r_lo; r_j <= r_hi;
                    r_st <= S_PIVW;
                end
                S_PIVW: begin
                    r_piv <= rdata; r_st <= S_RI;
                end
                S_RI: r_st <= S_TI;
                S_TI: begin
                    if ($signed(r_i) < $signed(r_hi) && rdata < r_piv) begin
                        r_i <= r_i + 1'b1; r_st <= S_RI;
                    end else begin
                        r_vi <= rdata; r_st <= S_RJ;
                    end
                end
                S_RJ: r_st <= S_TJ;
                S_TJ: begin
                    if ($signed(r_j) > $signed(r_lo) && rdata > r_piv) begin
                        r_j <= r_j - 1'b1; r_st <= S_RJ;
                    end else begin
                        r_vj <= rdata;
                        if ($signed(r_i) <= $signed(r_j)) r_st <= S_SW1;
                        else begin r_p2 <= 1'b0; r_st <= S_PUSH; end
                    end
                end
                S_SW1: r_st <= S_SW2;
                S_SW2: begin
                    r_i <= r_i + 1'b1; r_j <= r_j - 1'b1;
                    if ($signed(r_i + 1'b1) <= $signed(r_j - 1'b1)) r_st <= S_RI;
                    else begin r_p2 <= 1'b0; r_st <= S_PUSH; end
                end
                S_PUSH: begin
                    if (st_we) r_sp <= r_sp + SW'(1);
                    if (!r_p2) r_p2 <= 1'b1;
                    else r_st <= S_POP;
                end
                S_ERD: begin
                    if (!r_ov || m_axis_tready) begin
                        if (r_k == r_cnt) begin
                            r_st <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_sp <= '0;
                        end else r_st <= S_EWT;
                    end
                end
                S_EWT: begin
                    r_ov <= 1'b1;
                    r_od <= rdata ^ 32'h8000_0000;
                    r_ol <= (r_k + CW'(1) == r_cnt);
                    r_k <= r_k + CW'(1);
                    r_st <= S_ERD;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_ol;
    assign m_axis_tuser  = r_ovf;

    `ASSERT_NEVER(a_no_load_while_out, i_clk, i_rst_n, s_axis_tready && r_ov)
    `ASSERT_IMPL(a_hold_stall, i_clk, i_rst_n,
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_od)))
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CW'(DEPTH))
    `ASSERT_NEVER(a_sp_range, i_clk, i_rst_n, r_sp > SW'(SD))
endmodule

// ----- rtl/core/qse_store.sv -----
// Element store: one write port, one registered read port.
module qse_store import qse_pkg::*; (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);
    logic [31:0] mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end
endmodule

// ----- rtl/core/qse_stack.sv -----
// Range stack memory: one write port, one registered read port.
module qse_stack import qse_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [SW-1:0]       i_waddr,
    input  logic [2*AW-1:0]     i_wdata,
    input  logic [SW-1:0]       i_raddr,
    output logic [2*AW-1:0]     o_rdata
);
    logic [2*AW-1:0] mem [SD];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr[$clog2(SD)-1:0]] <= i_wdata;
        end
        o_rdata <= mem[i_raddr[$clog2(SD)-1:0]];
    end
endmodule
